[hdl/pblep_pkg.sv]
// Shared constants, command and status types, and the sine table for the PolyBLEP oscillator.
package pblep_pkg;

	localparam int PHASE_W     = 32;
	localparam int INC_W       = 31;
	localparam int SAMPLE_W    = 16;
	localparam int WAVE_W      = 3;
	localparam int PW_W        = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
	localparam int QUO_W       = 30;
	localparam int DIV_STEPS   = QUO_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int V_W         = 34;
	localparam int MAG_W       = 31;

	localparam logic [WAVE_W-1:0] WF_SINE   = 3'd0;
	localparam logic [WAVE_W-1:0] WF_SAW    = 3'd1;
	localparam logic [WAVE_W-1:0] WF_SQUARE = 3'd2;
	localparam logic [WAVE_W-1:0] WF_TRI    = 3'd3;
	localparam logic [WAVE_W-1:0] WF_PULSE  = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY     = 1'd1;

	localparam logic [WAVE_W-1:0] WAVE_RESET = WF_SAW;
	localparam logic [PW_W-1:0]   PW_RESET   = 16'd32768;
	localparam logic [PW_W-1:0]   PW_MIN     = 16'd655;
	localparam logic [PW_W-1:0]   PW_MAX     = 16'd64880;

	localparam logic signed [V_W-1:0] Q30_ONE = 34'sd1073741824;

	typedef struct packed {
		logic load;
		logic base;
		logic div_start;
		logic pass;
		logic mul;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_blep;
		logic need_two;
		logic out_full;
	} status_t;

	typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint ONE_Q30     = 64'sd1073741824;

	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int i);
		longint x;
		longint m;
		longint x2;
		longint t;
		longint s;
		longint q;
		logic neg;
		logic signed [SAMPLE_W-1:0] res;
		x = (longint'(i) * TWO_PI_Q30) / SINE_DEPTH;
		if (x > PI_Q30) begin
			x = x - TWO_PI_Q30;
		end
		if (x > HALF_PI_Q30) begin
			x = PI_Q30 - x;
		end else if (x < -HALF_PI_Q30) begin
			x = -PI_Q30 - x;
		end
		neg = (x < 0);
		m = neg ? -x : x;
		x2 = (m * m) >>> 30;
		t = ONE_Q30 - x2 / 72;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 42;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 20;
		t = ONE_Q30 - ((x2 * t) >>> 30) / 6;
		s = (m * t) >>> 30;
		q = (s + 32768) >>> 16;
		res = SAMPLE_W'(q);
		return neg ? -res : res;
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t r;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			r[i] = sine_entry(i);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

[hdl/pblep_div.sv]
// Radix-4 restoring divider for the PolyBLEP fraction, two quotient bits per cycle.
module pblep_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pblep_pkg::INC_W-1:0]   num,
	input  logic [pblep_pkg::INC_W-1:0]   den,
	output logic                          done,
	output logic [pblep_pkg::QUO_W-1:0]   quo
);

	logic                              busy_q;
	logic                              done_q;
	logic [pblep_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [pblep_pkg::INC_W-1:0]       rem_q;
	logic [pblep_pkg::QUO_W-1:0]       quo_q;
	logic [pblep_pkg::INC_W:0]         r1;
	logic [pblep_pkg::INC_W:0]         r1s;
	logic [pblep_pkg::INC_W:0]         r2;
	logic [pblep_pkg::INC_W:0]         r2s;
	logic                              ge1;
	logic                              ge2;

	always_comb begin
		r1  = {rem_q, 1'b0};
		ge1 = (r1 >= {1'b0, den});
		r1s = ge1 ? (r1 - {1'b0, den}) : r1;
		r2  = {r1s[pblep_pkg::INC_W-1:0], 1'b0};
		ge2 = (r2 >= {1'b0, den});
		r2s = ge2 ? (r2 - {1'b0, den}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == pblep_pkg::DIV_CNT_W'(pblep_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2s[pblep_pkg::INC_W-1:0];
			quo_q <= {quo_q[pblep_pkg::QUO_W-3:0], ge1, ge2};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/pblep_dp.sv]
// Datapath: phase accumulator, config registers, waveform base, PolyBLEP terms and output register.
module pblep_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pblep_pkg::cmd_t                    cmd,
	output pblep_pkg::status_t                 sts,
	input  logic [pblep_pkg::INC_W-1:0]        phase_increment,
	input  logic                               restart,
	input  logic                               cfg_valid,
	input  logic [pblep_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pblep_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [pblep_pkg::SAMPLE_W-1:0] sample
);

	logic [pblep_pkg::WAVE_W-1:0]       wave_q;
	logic [pblep_pkg::PW_W-1:0]         pw_q;
	logic [pblep_pkg::PHASE_W-1:0]      acc_q;
	logic [pblep_pkg::PHASE_W-1:0]      p_q;
	logic [pblep_pkg::INC_W-1:0]        inc_q;
	logic signed [pblep_pkg::SAMPLE_W-1:0] rom_q;
	logic signed [pblep_pkg::V_W-1:0]   v_q;
	logic                               lo_q;
	logic                               hi_q;
	logic                               sub_q;
	logic [pblep_pkg::MAG_W-1:0]        mag_q;
	logic signed [pblep_pkg::SAMPLE_W-1:0] out_q;
	logic                               out_valid_q;

	logic [pblep_pkg::PHASE_W-1:0]      p_start;
	logic [pblep_pkg::PW_W-1:0]         pw_clamped;
	logic [pblep_pkg::PHASE_W-1:0]      edge_pos;
	logic [pblep_pkg::PHASE_W-1:0]      t2;
	logic [pblep_pkg::PHASE_W-1:0]      t_sel;
	logic [pblep_pkg::PHASE_W-1:0]      dt;
	logic                               win_lo;
	logic                               win_hi;
	logic                               dt_nz;
	logic [pblep_pkg::PHASE_W-1:0]      num_full;
	logic signed [pblep_pkg::V_W-1:0]   base_v;
	logic                               div_done;
	logic [pblep_pkg::QUO_W-1:0]        quo;
	logic [pblep_pkg::MAG_W-1:0]        mul_op;
	logic [2*pblep_pkg::MAG_W-1:0]      prod;
	logic signed [pblep_pkg::V_W-1:0]   blep_v;
	logic signed [pblep_pkg::V_W-1:0]   v_rnd;
	logic signed [pblep_pkg::V_W-17:0]  v_sh;
	logic signed [pblep_pkg::SAMPLE_W-1:0] sat_v;

	function automatic logic [pblep_pkg::MAG_W-1:0] MAG_W_ONE();
		return {1'b1, {(pblep_pkg::MAG_W-1){1'b0}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= pblep_pkg::WAVE_RESET;
			pw_q   <= pblep_pkg::PW_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pblep_pkg::REG_WAVEFORM: wave_q <= cfg_data[pblep_pkg::WAVE_W-1:0];
				pblep_pkg::REG_DUTY:     pw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign p_start = restart ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.load) begin
			acc_q <= p_start + {1'b0, phase_increment};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q   <= p_start;
			inc_q <= phase_increment;
		end
		rom_q <= pblep_pkg::SINE_ROM[p_q[pblep_pkg::PHASE_W-1 -: pblep_pkg::SINE_ADDR_W]];
	end

	always_comb begin
		if (pw_q < pblep_pkg::PW_MIN) begin
			pw_clamped = pblep_pkg::PW_MIN;
		end else if (pw_q > pblep_pkg::PW_MAX) begin
			pw_clamped = pblep_pkg::PW_MAX;
		end else begin
			pw_clamped = pw_q;
		end
		edge_pos = (wave_q == pblep_pkg::WF_SQUARE) ? {1'b1, {(pblep_pkg::PHASE_W-1){1'b0}}}
			: {pw_clamped, {(pblep_pkg::PHASE_W-pblep_pkg::PW_W){1'b0}}};
		t2 = p_q - edge_pos;
	end

	always_comb begin
		case (wave_q)
			pblep_pkg::WF_SINE:
				base_v = {{(pblep_pkg::V_W-32){rom_q[pblep_pkg::SAMPLE_W-1]}}, rom_q, 16'h0000};
			pblep_pkg::WF_SAW:
				base_v = $signed({3'b000, p_q[pblep_pkg::PHASE_W-1:1]}) - pblep_pkg::Q30_ONE;
			pblep_pkg::WF_SQUARE, pblep_pkg::WF_PULSE:
				base_v = (p_q < edge_pos) ? pblep_pkg::Q30_ONE : -pblep_pkg::Q30_ONE;
			pblep_pkg::WF_TRI:
				if (!p_q[pblep_pkg::PHASE_W-1]) begin
					base_v = $signed({2'b00, p_q}) - pblep_pkg::Q30_ONE;
				end else begin
					base_v = $signed({2'b01, 32'h0000_0000}) - $signed({2'b00, p_q})
						- pblep_pkg::Q30_ONE;
				end
			default:
				base_v = '0;
		endcase
	end

	always_comb begin
		t_sel    = cmd.pass ? t2 : p_q;
		dt       = {1'b0, inc_q};
		dt_nz    = (inc_q != '0);
		win_lo   = (t_sel < dt);
		win_hi   = ({1'b0, t_sel} > ({1'b1, {pblep_pkg::PHASE_W{1'b0}}} - {1'b0, dt}));
		num_full = win_lo ? t_sel : (t_sel + dt);
	end

	pblep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_full[pblep_pkg::INC_W-1:0]),
		.den    (inc_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		mul_op = lo_q ? (MAG_W_ONE() - {1'b0, quo}) : {1'b0, quo};
		prod   = mul_op * mul_op;
		if (hi_q) begin
			blep_v = $signed({3'b000, mag_q});
		end else if (lo_q) begin
			blep_v = -$signed({3'b000, mag_q});
		end else begin
			blep_v = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.base) begin
			v_q <= base_v;
		end else if (cmd.acc) begin
			v_q <= sub_q ? (v_q - blep_v) : (v_q + blep_v);
		end
		if (cmd.div_start) begin
			lo_q  <= win_lo & dt_nz;
			hi_q  <= win_hi & ~win_lo & dt_nz;
			sub_q <= cmd.pass | (wave_q == pblep_pkg::WF_SAW);
		end
		if (cmd.mul) begin
			mag_q <= prod[2*pblep_pkg::MAG_W-2:pblep_pkg::MAG_W-1];
		end
	end

	always_comb begin
		v_rnd = v_q + pblep_pkg::V_W'(32768);
		v_sh  = v_rnd[pblep_pkg::V_W-1:16];
		if (v_sh > $signed(18'sd32767)) begin
			sat_v = 16'sh7FFF;
		end else if (v_sh < -$signed(18'sd32768)) begin
			sat_v = 16'sh8000;
		end else begin
			sat_v = v_sh[pblep_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= sat_v;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.need_blep = (wave_q == pblep_pkg::WF_SAW) || (wave_q == pblep_pkg::WF_SQUARE)
		|| (wave_q == pblep_pkg::WF_PULSE);
	assign sts.need_two  = (wave_q == pblep_pkg::WF_SQUARE) || (wave_q == pblep_pkg::WF_PULSE);
	assign sts.out_full  = out_valid_q;

	assign out_valid = out_valid_q;
	assign sample    = out_q;

endmodule

[hdl/pblep_ctrl.sv]
// Controller: sequences phase load, table read, base value, correction passes and output write.
module pblep_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  pblep_pkg::status_t  sts,
	output pblep_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROM,
		ST_BASE,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   pass_q;

	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.base      = (state_q == ST_BASE);
		cmd.div_start = ((state_q == ST_BASE) && sts.need_blep)
			|| ((state_q == ST_ACC) && !pass_q && sts.need_two);
		cmd.pass      = (state_q == ST_ACC);
		cmd.mul       = (state_q == ST_MUL);
		cmd.acc       = (state_q == ST_ACC);
		cmd.out_load  = (state_q == ST_DONE) && (!sts.out_full || out_ready);
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					pass_q  <= 1'b0;
					state_q <= sts.need_blep ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (cmd.div_start) begin
						pass_q  <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_to_rom: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_ROM)
		else $error("accepted word did not start the table read");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !sts.div_done |=> state_q == ST_DIV)
		else $error("left divide wait before the quotient was ready");

	a_start_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == ST_DIV && !sts.div_done)
		else $error("divide start not followed by divide wait");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full || out_ready)
		else $error("output register overwritten while holding a word");

	a_second_pass_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC && pass_q |=> state_q == ST_DONE)
		else $error("more than two correction passes");

endmodule

[hdl/polyblep_oscillator.sv]
// Top level of the PolyBLEP oscillator: controller and datapath.
//
// One input word is one sample tick: the phase is optionally cleared, a sample is rendered at
// the current phase, and the increment is added with wrap. Sine and triangle and silence need
// no PolyBLEP correction; the saw needs one and the square and pulse two. Each correction runs
// through one shared divider that produces two quotient bits per cycle, followed by one
// multiply and one accumulate. A finished sample waits in the output register while the next
// word is taken; a new sample is written only once the previous one has been taken.
// Configuration writes are accepted in every cycle.
module polyblep_oscillator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [pblep_pkg::INC_W-1:0]           phase_increment,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pblep_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pblep_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pblep_pkg::CFG_DATA_W-1:0]      cfg_data
);

	pblep_pkg::cmd_t    cmd;
	pblep_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	pblep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pblep_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.phase_increment (phase_increment),
		.restart         (restart),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.sample          (sample)
	);

endmodule

[sim/tb_top.sv]
// Self-checking testbench for polyblep_oscillator: directed and random stimulus checked against a sample predictor.

class osc_scoreboard;
	localparam longint    Q30_UNIT  = 64'sd1073741824;
	localparam longint    PI30      = 64'sd3373259426;
	localparam longint    HALF_PI30 = 64'sd1686629713;
	localparam longint    TWO_PI30  = 64'sd6746518852;
	localparam bit [63:0] WRAP      = 64'h1_0000_0000;
	localparam bit [63:0] HALF      = 64'h8000_0000;
	localparam bit [15:0] PW_LO     = 16'd655;
	localparam bit [15:0] PW_HI     = 16'd64880;

	int                 sine_tab [pblep_pkg::SINE_DEPTH];
	bit [31:0]          phase;
	bit [2:0]           wave;
	bit [15:0]          duty;
	logic signed [15:0] want_samples [$];
	int                 errors;

	function new();
		phase = 0;
		wave = pblep_pkg::WF_SAW;
		duty = 16'd32768;
		errors = 0;
		for (int i = 0; i < pblep_pkg::SINE_DEPTH; i++) begin
			sine_tab[i] = sine_q14(i);
		end
	endfunction

	// quarter-wave Taylor series to x^9 in Q30, rounded to Q1.14
	function int sine_q14(int i);
		longint    x;
		bit [63:0] m;
		bit [63:0] x2;
		bit [63:0] t;
		bit [63:0] s;
		bit [63:0] q;
		bit        neg;
		x = (longint'(i) * TWO_PI30) / pblep_pkg::SINE_DEPTH;
		if (x > PI30) begin
			x -= TWO_PI30;
		end
		if (x > HALF_PI30) begin
			x = PI30 - x;
		end else if (x < -HALF_PI30) begin
			x = -PI30 - x;
		end
		neg = x < 0;
		m = neg ? -x : x;
		x2 = (m * m) >> 30;
		t = Q30_UNIT - x2 / 72;
		t = Q30_UNIT - ((x2 * t) >> 30) / 42;
		t = Q30_UNIT - ((x2 * t) >> 30) / 20;
		t = Q30_UNIT - ((x2 * t) >> 30) / 6;
		s = (m * t) >> 30;
		q = (s + 32768) >> 16;
		return neg ? -int'(q) : int'(q);
	endfunction

	function longint blep_q30(bit [63:0] t, bit [63:0] dt);
		bit [63:0] u;
		bit [63:0] a;
		bit [63:0] w;
		if (dt == 0) begin
			return 0;
		end
		if (t < dt) begin
			u = (t << 30) / dt;
			a = Q30_UNIT - u;
			return -longint'((a * a) >> 30);
		end
		if (t > WRAP - dt) begin
			w = ((t - (WRAP - dt)) << 30) / dt;
			return longint'((w * w) >> 30);
		end
		return 0;
	endfunction

	function logic signed [15:0] render_q14(bit [63:0] p, bit [63:0] dt);
		longint    v;
		longint    q;
		bit [63:0] pw32;
		case (wave)
			pblep_pkg::WF_SINE: begin
				v = longint'(sine_tab[(p * pblep_pkg::SINE_DEPTH) >> 32]) * 65536;
			end
			pblep_pkg::WF_SAW: begin
				v = longint'(p >> 1) - Q30_UNIT - blep_q30(p, dt);
			end
			pblep_pkg::WF_SQUARE: begin
				v = (p < HALF) ? Q30_UNIT : -Q30_UNIT;
				v += blep_q30(p, dt);
				v -= blep_q30((p + HALF) & (WRAP - 1), dt);
			end
			pblep_pkg::WF_TRI: begin
				v = (p < HALF) ? longint'(p) - Q30_UNIT : longint'(WRAP - p) - Q30_UNIT;
			end
			pblep_pkg::WF_PULSE: begin
				pw32 = (duty < PW_LO) ? PW_LO : (duty > PW_HI) ? PW_HI : duty;
				pw32 = pw32 << 16;
				v = (p < pw32) ? Q30_UNIT : -Q30_UNIT;
				v += blep_q30(p, dt);
				v -= blep_q30((p + (WRAP - pw32)) & (WRAP - 1), dt);
			end
			default: begin
				v = 0;
			end
		endcase
		q = (v + 32768) >>> 16;
		if (q > 32767) begin
			q = 32767;
		end else if (q < -32768) begin
			q = -32768;
		end
		return 16'(q);
	endfunction

	function void set_reg(bit [pblep_pkg::CFG_INDEX_W-1:0] idx, bit [15:0] data);
		if (idx == pblep_pkg::REG_WAVEFORM) begin
			wave = data[2:0];
		end else if (idx == pblep_pkg::REG_DUTY) begin
			duty = data;
		end
	endfunction

	function void note_word(bit [30:0] inc, bit rst);
		if (rst) begin
			phase = 0;
		end
		want_samples = {want_samples, render_q14(64'(phase), 64'(inc))};
		phase = phase + 32'(inc);
	endfunction

	function void check_sample(logic signed [15:0] got);
		logic signed [15:0] exp_s;
		if (want_samples.size() == 0) begin
			$error("sample: no word expected, got %0d", got);
			errors++;
		end else begin
			exp_s = want_samples.pop_front();
			if (got !== exp_s) begin
				$error("sample: expected %0d, got %0d", exp_s, got);
				errors++;
			end
		end
	endfunction

	function int pending();
		return want_samples.size();
	endfunction
endclass

module tb_top;

	localparam logic [pblep_pkg::WAVE_W-1:0] WAVE_LAST = 3'd7;
	localparam int QUIET_LIMIT = 5000;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic [pblep_pkg::INC_W-1:0]           phase_increment = '0;
	logic                                  restart = 1'b0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic signed [pblep_pkg::SAMPLE_W-1:0] sample;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [pblep_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [pblep_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	osc_scoreboard sb;
	int            src_idle = 0;
	int            sink_idle = 0;
	int            quiet_cycles;

	polyblep_oscillator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.phase_increment (phase_increment),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample          (sample),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic send_word(bit [pblep_pkg::INC_W-1:0] inc, bit rst);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		phase_increment <= inc;
		restart <= rst;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_word(inc, rst);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [pblep_pkg::CFG_INDEX_W-1:0] idx,
			logic [pblep_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(logic [pblep_pkg::WAVE_W-1:0] wf,
			logic [pblep_pkg::CFG_DATA_W-1:0] pw);
		cfg_write(pblep_pkg::REG_WAVEFORM, {13'($urandom), wf});
		cfg_write(pblep_pkg::REG_DUTY, pw);
		cfg_valid <= 1'b0;
	endtask

	// hold off until every sample is back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= sink_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			sb.check_sample(sample);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
					(cfg_valid && cfg_ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("polyblep_oscillator regression: fail");
		$finish;
	end

	initial begin
		logic [pblep_pkg::WAVE_W-1:0] dir_waves [5];
		logic [pblep_pkg::PW_W-1:0]   dir_pws [2];
		logic [pblep_pkg::WAVE_W-1:0] wf;
		logic [pblep_pkg::PW_W-1:0]   pw;
		bit [pblep_pkg::INC_W-1:0]    inc;
		int                           sent;
		int                           seg;
		int                           n;
		int                           note_len;

		dir_waves = '{pblep_pkg::WF_SAW, pblep_pkg::WF_SINE, pblep_pkg::WF_SQUARE,
			pblep_pkg::WF_TRI, pblep_pkg::WF_PULSE};
		dir_pws = '{16'h0000, 16'hFFFF};
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word('0, 1'b0);
		foreach (dir_waves[i]) begin
			drain();
			configure(dir_waves[i], 16'd32768);
			send_word('0, 1'b1);
			send_word(31'h7FFF_FFFF, 1'b0);
			send_word(31'h4000_0000, 1'b0);
		end
		for (int c = pblep_pkg::WF_PULSE + 1; c <= WAVE_LAST; c++) begin
			drain();
			configure(pblep_pkg::WAVE_W'(c), 16'd32768);
			send_word(31'h7FFF_FFFF, 1'b0);
		end
		foreach (dir_pws[i]) begin
			drain();
			configure(pblep_pkg::WF_PULSE, dir_pws[i]);
			send_word(31'h7FFF_FFFF, 1'b1);
			send_word(31'h7FFF_FFFF, 1'b0);
		end

		for (int mode = 0; mode < 3; mode++) begin
			src_idle = (mode == 0) ? 28 : (mode == 1) ? 65 : 0;
			sink_idle = (mode == 0) ? 65 : (mode == 1) ? 28 : 0;
			sent = 0;
			while (sent < 205) begin
				drain();
				if ($urandom_range(9) < 8) begin
					wf = pblep_pkg::WAVE_W'($urandom_range(pblep_pkg::WF_PULSE));
				end else begin
					wf = pblep_pkg::WAVE_W'($urandom_range(WAVE_LAST, pblep_pkg::WF_PULSE + 1));
				end
				case ($urandom_range(7))
					0: pw = 16'd655;
					1: pw = 16'd64880;
					2: pw = 16'($urandom_range(654));
					3: pw = 16'($urandom_range(65535, 64881));
					default: pw = 16'($urandom);
				endcase
				configure(wf, pw);
				seg = $urandom_range(60, 20);
				n = 0;
				while (n < seg) begin
					note_len = $urandom_range(24, 3);
					case ($urandom_range(9))
						0: inc = '0;
						1, 2: inc = 31'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
						3, 4: inc = 31'($urandom_range(32'h3FFF_FFFF, 32'h0100_0000));
						5: inc = 31'($urandom_range(65535));
						6: inc = 31'h7FFF_FFFF - 31'($urandom_range(15));
						default: inc = 31'($urandom);
					endcase
					for (int k = 0; k < note_len && n < seg; k++) begin
						if ($urandom_range(11) == 0) begin
							send_word(31'($urandom), 1'($urandom));
						end else begin
							send_word(inc, k == 0);
						end
						n++;
					end
				end
				sent += seg;
			end
		end

		drain();
		repeat (48) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("polyblep_oscillator regression: pass");
		end else begin
			$display("polyblep_oscillator regression: fail");
		end
		$finish;
	end
endmodule

[polyblep_oscillator.f]
hdl/pblep_pkg.sv
hdl/pblep_div.sv
hdl/pblep_dp.sv
hdl/pblep_ctrl.sv
hdl/polyblep_oscillator.sv
sim/tb_top.sv
